/* hdl/nfha_pkg.sv */
// ----------------------------------------------------------------------------
// nfha_pkg
// Shared types and codes for the next-fit handle allocator.
// ----------------------------------------------------------------------------
package nfha_pkg;

  localparam int CFG_W      = 9;
  localparam int GEN_W      = 24;
  localparam int HANDLE_W   = 32;
  localparam int ID_W       = 32;
  localparam int CFG_RESET  = 256;

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_BIND   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_NOT_FND  = 2'd2,
    STAT_MISMATCH = 2'd3
  } status_t;

  localparam logic [1:0] SLOT_FREE     = 2'd0;
  localparam logic [1:0] SLOT_RESERVED = 2'd1;
  localparam logic [1:0] SLOT_BOUND    = 2'd2;

  typedef struct packed {
    kind_t                 kind;
    logic [HANDLE_W-1:0]   handle;
    logic [ID_W-1:0]       object_id;
  } in_t;

  typedef struct packed {
    status_t               status;
    logic [HANDLE_W-1:0]   new_handle;
    logic [1:0]            slot_state;
    logic [ID_W-1:0]       stored_id;
  } out_t;

endpackage

/* hdl/nfha_slot_ram.sv */
// ----------------------------------------------------------------------------
// nfha_slot_ram
// Slot status and identifier memories, one shared address, registered reads.
// ----------------------------------------------------------------------------
module nfha_slot_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic [AW-1:0] addr,
  input  logic          st_we,
  input  logic [1:0]    st_wdata,
  input  logic          id_we,
  input  logic [31:0]   id_wdata,
  output logic [1:0]    st_rdata,
  output logic [31:0]   id_rdata
);

  logic [1:0]  st_mem [DEPTH];
  logic [31:0] id_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[addr] <= st_wdata;
    end
    st_rdata <= st_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (id_we) begin
      id_mem[addr] <= id_wdata;
    end
    id_rdata <= id_mem[addr];
  end

endmodule

/* hdl/nfha_scan_unit.sv */
// ----------------------------------------------------------------------------
// nfha_scan_unit
// Shared pointer step: optional increment, wrap against the limit, count test.
// ----------------------------------------------------------------------------
module nfha_scan_unit #(
  parameter int AW = 8,
  parameter int LW = 9
) (
  input  logic [AW-1:0] ptr,
  input  logic          inc,
  input  logic [LW-1:0] cnt,
  input  logic [LW-1:0] lim,
  output logic [AW-1:0] ptr_out,
  output logic          last
);

  logic [LW-1:0] q;

  assign q       = LW'(ptr) + (inc ? LW'(1) : LW'(0));
  assign ptr_out = (q >= lim) ? '0 : q[AW-1:0];
  assign last    = ((cnt + LW'(1)) == lim);

endmodule

/* hdl/next_fit_handle_allocator_unit.sv */
// ----------------------------------------------------------------------------
// next_fit_handle_allocator_unit
// Generational handle table with next-fit slot allocation.
// ----------------------------------------------------------------------------
// After reset the unit holds busy while it clears the slot status memory;
// configuration writes are taken meanwhile. An allocate examines slots one
// after another, at most as many as the slot limit: each slot costs one
// memory read and one evaluation by the shared pointer step unit. Free,
// lookup and bind read the slot and then evaluate it; they skip both when
// the index is out of range or the limit is zero. Results appear on
// out_result for exactly one cycle with out_valid and cannot be held off;
// a new start is taken while a result is being shown.
module next_fit_handle_allocator_unit #(
  parameter int TABLE_DEPTH = 256,
  parameter int INDEX_BITS  = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  nfha_pkg::in_t            in_item,
  output logic                     out_valid,
  output nfha_pkg::out_t           out_result,
  input  logic                     cfg_we,
  input  logic [nfha_pkg::CFG_W-1:0] cfg_wdata
);

  import nfha_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int DLW = $clog2(TABLE_DEPTH + 1);
  localparam int LW  = (DLW > CFG_W) ? DLW : CFG_W;

  typedef enum logic [5:0] {
    S_CLEAR   = 6'b000001,
    S_IDLE    = 6'b000010,
    S_SCAN_RD = 6'b000100,
    S_SCAN_EV = 6'b001000,
    S_OP_RD   = 6'b010000,
    S_OP_EV   = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     slots_r;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic [AW-1:0]        ptr_r, ptr_nxt;
  logic [LW-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]        rov_r, rov_nxt;
  logic [GEN_W-1:0]     gen_r, gen_nxt;
  in_t                  item_r, item_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_r, out_nxt;

  logic [LW-1:0]        lim;
  logic [INDEX_BITS-1:0] idx;
  logic                 idx_bad;
  logic [AW-1:0]        ram_addr;
  logic                 st_we, id_we;
  logic [1:0]           st_wdata, st_rdata;
  logic [31:0]          id_rdata;
  logic [AW-1:0]        su_ptr, su_ptr_out;
  logic                 su_inc, su_last;
  logic [GEN_W-1:0]     gen_inc;
  logic [47:0]          hnd_wide;

  assign lim = (LW'(slots_r) > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : LW'(slots_r);
  assign idx = in_item.handle[INDEX_BITS-1:0];
  assign idx_bad = (32'(idx) >= 32'(lim));
  assign gen_inc = gen_r + GEN_W'(1);
  assign hnd_wide = (48'(gen_inc) << INDEX_BITS) | 48'(ptr_r);

  assign su_ptr = (state_r == S_IDLE) ? rov_r : ptr_r;
  assign su_inc = (state_r != S_IDLE);

  nfha_scan_unit #(
    .AW (AW),
    .LW (LW)
  ) u_scan (
    .ptr     (su_ptr),
    .inc     (su_inc),
    .cnt     (cnt_r),
    .lim     (lim),
    .ptr_out (su_ptr_out),
    .last    (su_last)
  );

  always_comb begin
    case (state_r)
      S_CLEAR:               ram_addr = clr_r;
      S_OP_RD, S_OP_EV:      ram_addr = AW'(item_r.handle[INDEX_BITS-1:0]);
      default:               ram_addr = ptr_r;
    endcase
  end

  nfha_slot_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk      (clk),
    .addr     (ram_addr),
    .st_we    (st_we),
    .st_wdata (st_wdata),
    .id_we    (id_we),
    .id_wdata (item_r.object_id),
    .st_rdata (st_rdata),
    .id_rdata (id_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    rov_nxt       = rov_r;
    gen_nxt       = gen_r;
    item_nxt      = item_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    st_we         = 1'b0;
    st_wdata      = SLOT_FREE;
    id_we         = 1'b0;

    case (state_r)
      S_CLEAR: begin
        st_we   = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          if (in_item.kind == KIND_ALLOC) begin
            if (lim == '0) begin
              out_valid_nxt  = 1'b1;
              out_nxt.status = STAT_NO_SPACE;
              rov_nxt        = '0;
            end else begin
              ptr_nxt   = su_ptr_out;
              cnt_nxt   = '0;
              state_nxt = S_SCAN_RD;
            end
          end else if (idx_bad) begin
            out_valid_nxt  = 1'b1;
            out_nxt.status = STAT_NOT_FND;
          end else begin
            state_nxt = S_OP_RD;
          end
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (st_rdata == SLOT_FREE) begin
          st_we              = 1'b1;
          st_wdata           = SLOT_RESERVED;
          rov_nxt            = ptr_r;
          gen_nxt            = gen_inc;
          out_valid_nxt      = 1'b1;
          out_nxt.new_handle = hnd_wide[31:0];
          state_nxt          = S_IDLE;
        end else if (su_last) begin
          rov_nxt        = '0;
          out_valid_nxt  = 1'b1;
          out_nxt.status = STAT_NO_SPACE;
          state_nxt      = S_IDLE;
        end else begin
          ptr_nxt   = su_ptr_out;
          cnt_nxt   = cnt_r + LW'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_OP_RD: begin
        state_nxt = S_OP_EV;
      end
      S_OP_EV: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        case (item_r.kind)
          KIND_FREE: begin
            if (st_rdata == SLOT_FREE) begin
              out_nxt.status = STAT_NOT_FND;
            end else if (st_rdata == SLOT_BOUND && id_rdata != item_r.handle) begin
              out_nxt.status = STAT_MISMATCH;
            end else begin
              st_we    = 1'b1;
              st_wdata = SLOT_FREE;
            end
          end
          KIND_LOOKUP: begin
            out_nxt.slot_state = st_rdata;
            if (st_rdata == SLOT_BOUND) begin
              out_nxt.stored_id = id_rdata;
            end
          end
          KIND_BIND: begin
            if (st_rdata == SLOT_FREE) begin
              out_nxt.status = STAT_NOT_FND;
            end else begin
              st_we    = 1'b1;
              st_wdata = SLOT_BOUND;
              id_we    = 1'b1;
            end
          end
          default: begin
            out_valid_nxt = 1'b0;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      ptr_r       <= '0;
      cnt_r       <= '0;
      rov_r       <= '0;
      gen_r       <= GEN_W'(1);
      slots_r     <= CFG_W'(CFG_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      rov_r       <= rov_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        slots_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule
